FILE: sv/psfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psfd_pkg;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_SWEEP  = 1'b1;

   localparam logic [1:0] KIND_RATE  = 2'd0;
   localparam logic [1:0] KIND_RENEG = 2'd1;
   localparam logic [1:0] KIND_HOLD  = 2'd2;

   localparam logic [1:0] CSR_ATTEMPT   = 2'd0;
   localparam logic [1:0] CSR_HANDSHAKE = 2'd1;
   localparam logic [1:0] CSR_OPEN      = 2'd2;

   // one table slot: source address plus old/new memory per rule
   typedef struct packed {
      logic        used;
      logic [31:0] addr;
      logic        rate_ov;
      logic [63:0] rate_ow;
      logic        rate_nv;
      logic [63:0] rate_nw;
      logic        reneg_ov;
      logic [63:0] reneg_ow;
      logic        reneg_nv;
      logic [63:0] reneg_nw;
      logic        hold_ov;
      logic [31:0] hold_ol;
      logic        hold_nv;
      logic [31:0] hold_nl;
   } slot_type;

endpackage
`default_nettype wire

FILE: sv/psfd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface psfd_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic [31:0]        source_addr;
   logic [31:0]        attempt_cnt;
   logic [31:0]        handshake_cnt;
   logic signed [31:0] open_count;
   logic [63:0]        window_start;
   modport source (output valid, command, source_addr, attempt_cnt, handshake_cnt,
                   open_count, window_start, input ready);
   modport sink (input valid, command, source_addr, attempt_cnt, handshake_cnt,
                 open_count, window_start, output ready);
endinterface

interface psfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [31:0] event_source;
   logic [31:0] event_count;
   logic [31:0] event_limit;
   logic        last_event;
   modport source (output valid, event_kind, event_source, event_count, event_limit,
                   last_event, input ready);
   modport sink (input valid, event_kind, event_source, event_count, event_limit,
                 last_event, output ready);
endinterface
`default_nettype wire

FILE: sv/psfd_table.sv
`timescale 1ns / 1ps
`default_nettype none
module psfd_table #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output psfd_pkg::slot_type       rd_data,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire psfd_pkg::slot_type  wr_data
);
   import psfd_pkg::*;

   slot_type mem_ff [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/per_source_flood_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-source flood detector.
// req_bus carries counter records (command 0) and end-of-sweep markers
// (command 1); rsp_bus carries one event per rule that fires and is not
// already remembered, rules in order rate, renegotiation, slow-hold, with
// last_event set on the final event of a request. csr_* writes the three
// limits; write them only while the block is idle.
// A record that fires no rule, or any request while every limit is zero,
// is taken and leaves the block idle. A firing record scans the slot
// table one entry per cycle through its single read port, then commits
// its slot and emits its events as the receiver takes them. End of sweep
// is a read-modify-write pass over the table. After reset the table is
// cleared one slot per cycle, during which no request is taken (csr
// writes still land).
// When the receiver stalls the pending event sits in the output register
// and the block waits; no event is dropped. Once the last event is loaded
// the next request may be taken while that event still waits.
module per_source_flood_detector #(
   parameter int SOURCES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   psfd_req_if.sink         req_bus,
   psfd_rsp_if.source       rsp_bus,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import psfd_pkg::*;

   localparam int IW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam logic [IW:0] LAST_CNT = (IW+1)'(SOURCES);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_SWEEP  = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   // limits
   logic [31:0] att_lim_ff, hs_lim_ff, open_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         att_lim_ff  <= '0;
         hs_lim_ff   <= '0;
         open_lim_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ATTEMPT:   att_lim_ff  <= csr_wdata;
            CSR_HANDSHAKE: hs_lim_ff   <= csr_wdata;
            CSR_OPEN:      open_lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control
   logic [2:0]    state_ff, state_in;
   logic [IW:0]   cnt_ff, cnt_in;
   logic          rvalid_ff, rvalid_in;
   logic [IW-1:0] ridx_ff, ridx_in;

   // request held during scan
   logic [31:0] addr_ff, addr_in, att_ff, att_in, hs_ff, hs_in, open_ff, open_in;
   logic [63:0] ws_ff, ws_in;
   logic [2:0]  fire_ff, fire_in;

   // scan results
   logic          found_ff, found_in, free_ff, free_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   slot_type      hit_ent_ff, hit_ent_in;

   // pending events
   logic [2:0] mask_ff, mask_in;

   // output register
   logic        ov_ff, ov_in, olast_ff, olast_in;
   logic [1:0]  okind_ff, okind_in;
   logic [31:0] osrc_ff, osrc_in, ocnt_ff, ocnt_in, olim_ff, olim_in;

   // table port
   logic          rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   slot_type      rd_data, wr_data;

   psfd_table #(.DEPTH(SOURCES), .AW(IW)) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   logic     req_fire_rate, req_fire_reneg, req_fire_hold, open_pos, all_off, rsp_free;
   logic     have_slot, rate_known, reneg_known, hold_known;
   slot_type base_ent, new_ent, swap_ent;
   logic [IW-1:0] slot_idx;

   assign all_off = (att_lim_ff == '0) && (hs_lim_ff == '0) && (open_lim_ff == '0);
   assign open_pos = (req_bus.open_count > 32'sd0);
   assign req_fire_rate  = (att_lim_ff != '0) && (req_bus.attempt_cnt >= att_lim_ff);
   assign req_fire_reneg = (hs_lim_ff != '0) && (req_bus.handshake_cnt >= hs_lim_ff);
   assign req_fire_hold  = (open_lim_ff != '0) && open_pos
                           && (32'(req_bus.open_count) >= open_lim_ff);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_free = !ov_ff || rsp_bus.ready;

   always_comb begin
      // commit: existing slot, else a fresh one if a slot is free
      base_ent = hit_ent_ff;
      if (!found_ff) begin
         base_ent = '0;
         base_ent.used = 1'b1;
         base_ent.addr = addr_ff;
      end
      have_slot = found_ff || free_ff;
      slot_idx  = found_ff ? hit_idx_ff : free_idx_ff;
      rate_known  = have_slot && base_ent.rate_ov && (base_ent.rate_ow == ws_ff);
      reneg_known = have_slot && base_ent.reneg_ov && (base_ent.reneg_ow == ws_ff);
      hold_known  = have_slot && base_ent.hold_ov && (open_ff <= base_ent.hold_ol);
      new_ent = base_ent;
      if (fire_ff[0]) begin
         new_ent.rate_nv = 1'b1;
         new_ent.rate_nw = ws_ff;
      end
      if (fire_ff[1]) begin
         new_ent.reneg_nv = 1'b1;
         new_ent.reneg_nw = ws_ff;
      end
      if (fire_ff[2]) begin
         new_ent.hold_nv = 1'b1;
         new_ent.hold_nl = open_ff;
      end

      // end of sweep: new memory becomes old
      swap_ent = rd_data;
      swap_ent.rate_ov  = rd_data.used && rd_data.rate_nv;
      swap_ent.rate_ow  = rd_data.rate_nw;
      swap_ent.reneg_ov = rd_data.used && rd_data.reneg_nv;
      swap_ent.reneg_ow = rd_data.reneg_nw;
      swap_ent.hold_ov  = rd_data.used && rd_data.hold_nv;
      swap_ent.hold_ol  = rd_data.hold_nl;
      swap_ent.rate_nv  = 1'b0;
      swap_ent.reneg_nv = 1'b0;
      swap_ent.hold_nv  = 1'b0;
      swap_ent.used = swap_ent.rate_ov || swap_ent.reneg_ov || swap_ent.hold_ov;
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rvalid_in   = 1'b0;
      ridx_in     = ridx_ff;
      addr_in     = addr_ff;
      att_in      = att_ff;
      hs_in       = hs_ff;
      open_in     = open_ff;
      ws_in       = ws_ff;
      fire_in     = fire_ff;
      found_in    = found_ff;
      free_in     = free_ff;
      hit_idx_in  = hit_idx_ff;
      free_idx_in = free_idx_ff;
      hit_ent_in  = hit_ent_ff;
      mask_in     = mask_ff;
      ov_in       = ov_ff && !rsp_bus.ready;
      okind_in    = okind_ff;
      osrc_in     = osrc_ff;
      ocnt_in     = ocnt_ff;
      olim_in     = olim_ff;
      olast_in    = olast_ff;
      rd_en       = 1'b0;
      rd_addr     = cnt_ff[IW-1:0];
      wr_en       = 1'b0;
      wr_addr     = cnt_ff[IW-1:0];
      wr_data     = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CNT - 1'b1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid && !all_off) begin
               addr_in  = req_bus.source_addr;
               att_in   = req_bus.attempt_cnt;
               hs_in    = req_bus.handshake_cnt;
               open_in  = 32'(req_bus.open_count);
               ws_in    = req_bus.window_start;
               fire_in  = {req_fire_hold, req_fire_reneg, req_fire_rate};
               cnt_in   = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               if (req_bus.command == CMD_SWEEP) begin
                  state_in = ST_SWEEP;
               end else if (req_fire_rate || req_fire_reneg || req_fire_hold) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff != LAST_CNT) begin
               rd_en     = 1'b1;
               rvalid_in = 1'b1;
               ridx_in   = cnt_ff[IW-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rvalid_ff) begin
               if (rd_data.used && (rd_data.addr == addr_ff) && !found_ff) begin
                  found_in   = 1'b1;
                  hit_idx_in = ridx_ff;
                  hit_ent_in = rd_data;
               end
               if (!rd_data.used && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = ridx_ff;
               end
            end else if (cnt_ff == LAST_CNT) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            wr_en   = have_slot;
            wr_addr = slot_idx;
            wr_data = new_ent;
            mask_in = fire_ff & ~{hold_known, reneg_known, rate_known};
            state_in = ST_EMIT;
         end
         ST_SWEEP: begin
            if (cnt_ff != LAST_CNT) begin
               rd_en     = 1'b1;
               rvalid_in = 1'b1;
               ridx_in   = cnt_ff[IW-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rvalid_ff) begin
               wr_en   = 1'b1;
               wr_addr = ridx_ff;
               wr_data = swap_ent;
            end else if (cnt_ff == LAST_CNT) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (mask_ff == '0) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               ov_in   = 1'b1;
               osrc_in = addr_ff;
               if (mask_ff[0]) begin
                  okind_in = KIND_RATE;
                  ocnt_in  = att_ff;
                  olim_in  = att_lim_ff;
                  mask_in  = {mask_ff[2:1], 1'b0};
               end else if (mask_ff[1]) begin
                  okind_in = KIND_RENEG;
                  ocnt_in  = hs_ff;
                  olim_in  = hs_lim_ff;
                  mask_in  = {mask_ff[2], 2'b00};
               end else begin
                  okind_in = KIND_HOLD;
                  ocnt_in  = open_ff;
                  olim_in  = open_lim_ff;
                  mask_in  = 3'b000;
               end
               olast_in = (mask_in == '0);
               if (mask_in == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
         mask_ff   <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rvalid_ff <= rvalid_in;
         mask_ff   <= mask_in;
         ov_ff     <= ov_in;
      end
      ridx_ff     <= ridx_in;
      addr_ff     <= addr_in;
      att_ff      <= att_in;
      hs_ff       <= hs_in;
      open_ff     <= open_in;
      ws_ff       <= ws_in;
      fire_ff     <= fire_in;
      found_ff    <= found_in;
      free_ff     <= free_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      hit_ent_ff  <= hit_ent_in;
      okind_ff    <= okind_in;
      osrc_ff     <= osrc_in;
      ocnt_ff     <= ocnt_in;
      olim_ff     <= olim_in;
      olast_ff    <= olast_in;
   end

   assign rsp_bus.valid        = ov_ff;
   assign rsp_bus.event_kind   = okind_ff;
   assign rsp_bus.event_source = osrc_ff;
   assign rsp_bus.event_count  = ocnt_ff;
   assign rsp_bus.event_limit  = olim_ff;
   assign rsp_bus.last_event   = olast_ff;

endmodule
`default_nettype wire
